// ===== hdl/lphm_pkg.sv =====
// Shared types, constants and helpers for the linear-probe hash map.
// No dependencies; every other file imports this package.
package lphm_pkg;

    localparam int CAPACITY  = 256;
    localparam int SLOT_W    = $clog2(CAPACITY + 1) - 1;
    localparam int SLOTS     = 1 << SLOT_W;
    localparam int KEY_W     = 64;
    localparam int VAL_W     = 12;
    localparam int STAT_W    = 3;
    localparam int CFG_W     = 4;
    localparam int HASH_SHIFT = 32;
    localparam int PROD_W    = HASH_SHIFT + SLOT_W;
    localparam int HALF_W    = (PROD_W + 1) / 2;

    localparam logic [KEY_W-1:0] FIB_MULT = 64'h9e3779b97f4a7c15;
    localparam logic [CFG_W-1:0] SIZE_RST = CFG_W'(8);

    typedef enum logic [STAT_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_FULL      = 3'd2,
        ST_HIT       = 3'd3,
        ST_MISS      = 3'd4
    } t_status;

    typedef enum logic [0:0] {
        ACT_INSERT = 1'b0,
        ACT_LOOKUP = 1'b1
    } t_action;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HASH,
        S_READ,
        S_CHECK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_entry;

    typedef struct packed {
        logic [SLOT_W-1:0] addr;
        logic              wr_en;
        t_entry            wr_data;
    } t_mem_req;

    typedef struct packed {
        logic   used;
        t_entry data;
    } t_mem_rsp;

    // probe mask from the size register; zero acts as one, large sizes saturate
    function automatic logic [SLOT_W-1:0] f_mask(input logic [CFG_W-1:0] size_log2);
        logic [CFG_W-1:0] s;
        s = size_log2;
        if (s == CFG_W'(0)) begin
            s = CFG_W'(1);
        end
        if (s > CFG_W'(SLOT_W)) begin
            s = CFG_W'(SLOT_W);
        end
        return SLOT_W'((SLOT_W'(1) << s) - SLOT_W'(1));
    endfunction

endpackage

// ===== hdl/lphm_if.sv =====
// Valid/ready channel interfaces for request and result items.
// Depends on lphm_pkg.
interface lphm_in_if import lphm_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             action;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;

    modport source (output valid, action, key, value, input ready);
    modport sink   (input valid, action, key, value, output ready);
endinterface

interface lphm_out_if import lphm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [VAL_W-1:0]  value_out;

    modport source (output valid, status, value_out, input ready);
    modport sink   (input valid, status, value_out, output ready);
endinterface

// ===== hdl/lphm_hash.sv =====
// Two-stage Fibonacci hash: split partial products, then add and slice the home slot.
// Depends on lphm_pkg.
module lphm_hash import lphm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [KEY_W-1:0]  i_key,
    output logic              o_valid,
    output logic [SLOT_W-1:0] o_home
);

    logic [HALF_W-1:0]   k_lo, k_hi, c_lo, c_hi;
    logic [2*HALF_W-1:0] r_p0;
    logic [HALF_W-1:0]   r_p1, r_p2;
    logic [HALF_W-1:0]   mid_sum;
    logic [2*HALF_W-1:0] sum;
    logic                r_v1, r_v2;
    logic [SLOT_W-1:0]   r_home;

    assign k_lo = i_key[HALF_W-1:0];
    assign k_hi = i_key[2*HALF_W-1:HALF_W];
    assign c_lo = FIB_MULT[HALF_W-1:0];
    assign c_hi = FIB_MULT[2*HALF_W-1:HALF_W];

    assign mid_sum = r_p1 + r_p2;
    assign sum     = r_p0 + {mid_sum, {HALF_W{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p0   <= (2*HALF_W)'(k_lo) * (2*HALF_W)'(c_lo);
        r_p1   <= HALF_W'(k_hi * c_lo);
        r_p2   <= HALF_W'(k_lo * c_hi);
        r_home <= sum[HASH_SHIFT +: SLOT_W];
    end

    assign o_valid = r_v2;
    assign o_home  = r_home;

endmodule

// ===== hdl/lphm_table.sv =====
// Slot store: key/value memory with registered read, plus used bits in flops.
// Depends on lphm_pkg.
module lphm_table import lphm_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mem_req i_req,
    output t_mem_rsp o_rsp
);

    t_entry            r_mem [SLOTS];
    logic [SLOTS-1:0]  r_used;
    t_entry            r_rd_data;
    logic              r_rd_used;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.addr] <= i_req.wr_data;
        end
        r_rd_data <= r_mem[i_req.addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used    <= '0;
            r_rd_used <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_used[i_req.addr] <= 1'b1;
            end
            r_rd_used <= r_used[i_req.addr];
        end
    end

    assign o_rsp.used = r_rd_used;
    assign o_rsp.data = r_rd_data;

endmodule

// ===== hdl/lphm_ctrl.sv =====
// Probe sequencer: walks slots from the home slot, decides the result, holds the output item.
// Depends on lphm_pkg and the channel interfaces.
module lphm_ctrl import lphm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    lphm_in_if.sink           i_in,
    lphm_out_if.source        o_out,
    input  logic [SLOT_W-1:0] i_mask,
    input  logic              i_hash_valid,
    input  logic [SLOT_W-1:0] i_hash_home,
    input  t_mem_rsp          i_rsp,
    output t_mem_req          o_req
);

    t_state            r_state, n_state;
    logic              r_action, n_action;
    logic [KEY_W-1:0]  r_key, n_key;
    logic [VAL_W-1:0]  r_value, n_value;
    logic [SLOT_W-1:0] r_idx, n_idx;
    logic [SLOT_W-1:0] r_probes, n_probes;
    t_status           r_res_status, n_res_status;
    logic [VAL_W-1:0]  r_res_vout, n_res_vout;
    logic              r_out_valid, n_out_valid;
    t_status           r_out_status, n_out_status;
    logic [VAL_W-1:0]  r_out_vout, n_out_vout;

    logic accept, lookup, match, last_probe, out_free;

    assign accept     = i_in.valid && (r_state == S_IDLE);
    assign lookup     = (r_action == ACT_LOOKUP);
    assign match      = i_rsp.used && (i_rsp.data.key == r_key);
    assign last_probe = (r_probes == i_mask);
    assign out_free   = !r_out_valid || o_out.ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (accept) n_state = S_HASH;
            S_HASH:  if (i_hash_valid) n_state = S_READ;
            S_READ:  n_state = S_CHECK;
            S_CHECK: begin
                if (!i_rsp.used || match || last_probe) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_READ;
                end
            end
            S_DONE:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_action     = r_action;
        n_key        = r_key;
        n_value      = r_value;
        n_idx        = r_idx;
        n_probes     = r_probes;
        n_res_status = r_res_status;
        n_res_vout   = r_res_vout;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_status = r_out_status;
        n_out_vout   = r_out_vout;
        o_req.addr         = r_idx;
        o_req.wr_en        = 1'b0;
        o_req.wr_data.key   = r_key;
        o_req.wr_data.value = r_value;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_action = i_in.action;
                    n_key    = i_in.key;
                    n_value  = i_in.value;
                    n_probes = '0;
                end
            end
            S_HASH: begin
                if (i_hash_valid) begin
                    n_idx = i_hash_home & i_mask;
                end
            end
            S_READ: begin
            end
            S_CHECK: begin
                n_res_vout = '0;
                if (!i_rsp.used) begin
                    n_res_status = lookup ? ST_MISS : ST_INSERTED;
                    o_req.wr_en  = !lookup;
                end else if (match) begin
                    n_res_status = lookup ? ST_HIT : ST_DUPLICATE;
                    n_res_vout   = lookup ? i_rsp.data.value : '0;
                end else if (last_probe) begin
                    n_res_status = lookup ? ST_MISS : ST_FULL;
                end else begin
                    n_idx    = (r_idx + SLOT_W'(1)) & i_mask;
                    n_probes = r_probes + SLOT_W'(1);
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_vout   = r_res_vout;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_action     <= n_action;
        r_key        <= n_key;
        r_value      <= n_value;
        r_idx        <= n_idx;
        r_probes     <= n_probes;
        r_res_status <= n_res_status;
        r_res_vout   <= n_res_vout;
        r_out_status <= n_out_status;
        r_out_vout   <= n_out_vout;
    end

    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = r_out_valid;
    assign o_out.status    = r_out_status;
    assign o_out.value_out = r_out_vout;

endmodule

// ===== hdl/linear_probe_hash_map.sv =====
// Open-addressing hash map, 64-bit keys to 12-bit values, linear probing from a
// Fibonacci-hashed home slot. One item is processed at a time. Each item passes
// through the pipelined hash, then one probe per slot probed (registered read of
// the slot memory, then compare and write-back), then hands its result to the
// output register and rearms. The output register lets a new item be accepted
// while a result waits. Used marks clear at reset with no sweep; the user must
// write size_log2 only while idle, and the block does not enforce it.
// Depends on lphm_pkg, lphm_if, lphm_hash, lphm_table, lphm_ctrl.
module linear_probe_hash_map import lphm_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    lphm_in_if.sink          i_in,
    lphm_out_if.source       o_out
);

    logic [CFG_W-1:0]  r_size_log2;
    logic [SLOT_W-1:0] mask;
    logic              accept;
    logic              hash_valid;
    logic [SLOT_W-1:0] hash_home;
    t_mem_req          mem_req;
    t_mem_rsp          mem_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_log2 <= SIZE_RST;
        end else if (i_cfg_we) begin
            r_size_log2 <= i_cfg_wdata;
        end
    end

    assign mask   = f_mask(r_size_log2);
    assign accept = i_in.valid && i_in.ready;

    lphm_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_key   (i_in.key),
        .o_valid (hash_valid),
        .o_home  (hash_home)
    );

    lphm_table u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mem_req),
        .o_rsp   (mem_rsp)
    );

    lphm_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_out        (o_out),
        .i_mask       (mask),
        .i_hash_valid (hash_valid),
        .i_hash_home  (hash_home),
        .i_rsp        (mem_rsp),
        .o_req        (mem_req)
    );

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !i_in.ready)
        else $error("item accepted while another is in flight");

    a_single_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_req.wr_en |=> !mem_req.wr_en)
        else $error("more than one slot write for an item");

    a_write_idle_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_req.wr_en |-> !i_in.ready)
        else $error("slot write while idle");

    a_vout_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status != ST_HIT) |-> (o_out.value_out == '0))
        else $error("value returned without a lookup hit");

endmodule
